FILE: design/lmscs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmscs_pkg
// Types, constants and microcode table of the LED matrix command sender.
// ----------------------------------------------------------------------------
package lmscs_pkg;

	localparam int GRID_COUNT     = 16;
	localparam int MAX_BRIGHTNESS = 8;

	localparam logic [7:0] CMD_DATA_AUTO   = 8'h40;
	localparam logic [7:0] CMD_DISPLAY_OFF = 8'h80;
	localparam logic [7:0] CMD_DISPLAY_ON  = 8'h88;
	localparam logic [7:0] CMD_ADDRESS     = 8'hC0;

	localparam logic [1:0] MODE_SETUP  = 2'd0;
	localparam logic [1:0] MODE_BRIGHT = 2'd1;
	localparam logic [1:0] MODE_GRID   = 2'd2;

	typedef logic [2:0] upc_t;

	localparam upc_t UPC_WAIT   = 3'd0;
	localparam upc_t UPC_START  = 3'd1;
	localparam upc_t UPC_BIT_LO = 3'd2;
	localparam upc_t UPC_BIT_HI = 3'd3;
	localparam upc_t UPC_STOP0  = 3'd4;
	localparam upc_t UPC_STOP1  = 3'd5;
	localparam upc_t UPC_STOP2  = 3'd6;

	typedef enum logic [1:0] {
		DS_ZERO,
		DS_ONE,
		DS_BIT
	} data_src_t;

	typedef enum logic [1:0] {
		BR_NEXT,
		BR_ACCEPT,
		BR_BITLOOP,
		BR_JUMP
	} branch_t;

	typedef struct packed {
		logic      emit;
		data_src_t dsrc;
		logic      clk_lvl;
		logic      last;
		logic      shift;
		branch_t   br;
		upc_t      target;
	} ucode_t;

	// datapath -> sequencer
	typedef struct packed {
		logic go;        // request produces a frame
		logic byte_end;  // bit 7 of the current byte
		logic more;      // second byte still to send
		logic out_free;  // output register can take a pin state
	} dp_status_t;

	function automatic ucode_t ucode_rom(input upc_t pc);
		ucode_t w;
		w = '{emit: 1'b0, dsrc: DS_ONE, clk_lvl: 1'b1, last: 1'b0, shift: 1'b0,
			br: BR_ACCEPT, target: UPC_START};
		case (pc)
			UPC_WAIT: begin
			end
			UPC_START: begin
				w = '{1'b1, DS_ZERO, 1'b1, 1'b0, 1'b0, BR_NEXT, UPC_WAIT};
			end
			UPC_BIT_LO: begin
				w = '{1'b1, DS_BIT, 1'b0, 1'b0, 1'b0, BR_NEXT, UPC_WAIT};
			end
			UPC_BIT_HI: begin
				w = '{1'b1, DS_BIT, 1'b1, 1'b0, 1'b1, BR_BITLOOP, UPC_BIT_LO};
			end
			UPC_STOP0: begin
				w = '{1'b1, DS_ZERO, 1'b0, 1'b0, 1'b0, BR_NEXT, UPC_WAIT};
			end
			UPC_STOP1: begin
				w = '{1'b1, DS_ZERO, 1'b1, 1'b0, 1'b0, BR_NEXT, UPC_WAIT};
			end
			UPC_STOP2: begin
				w = '{1'b1, DS_ONE, 1'b1, 1'b1, 1'b0, BR_JUMP, UPC_WAIT};
			end
			default: begin
				w = '{1'b0, DS_ONE, 1'b1, 1'b0, 1'b0, BR_JUMP, UPC_WAIT};
			end
		endcase
		return w;
	endfunction

endpackage

FILE: design/lmscs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmscs_seq
// Microprogram counter, control store lookup and branch logic.
// ----------------------------------------------------------------------------
module lmscs_seq
	import lmscs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  dp_status_t st,
	output ucode_t     uword,
	output logic       load,
	output logic       in_stall
);

	upc_t pc_q;
	logic advance;

	assign uword    = ucode_rom(pc_q);
	assign in_stall = (pc_q != UPC_WAIT);
	assign load     = in_valid && (pc_q == UPC_WAIT);
	// an emitting step waits until the output register takes its pin state
	assign advance  = !uword.emit || st.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= UPC_WAIT;
		end else begin
			case (uword.br)
				BR_ACCEPT: begin
					if (load && st.go)
						pc_q <= uword.target;
				end
				BR_NEXT: begin
					if (advance)
						pc_q <= pc_q + 3'd1;
				end
				BR_BITLOOP: begin
					if (advance) begin
						if (!st.byte_end || st.more)
							pc_q <= uword.target;
						else
							pc_q <= pc_q + 3'd1;
					end
				end
				BR_JUMP: begin
					if (advance)
						pc_q <= uword.target;
				end
				default: begin
					pc_q <= UPC_WAIT;
				end
			endcase
		end
	end

endmodule

FILE: design/lmscs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmscs_dp
// Command byte build, bit shifter, bit counter and output register.
// ----------------------------------------------------------------------------
module lmscs_dp
	import lmscs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] mode,
	input  logic [3:0] brightness,
	input  logic [7:0] grid,
	input  logic [7:0] dots,
	input  logic       load,
	input  ucode_t     uword,
	output dp_status_t st,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       data_level,
	output logic       clock_level,
	output logic       last
);

	logic [7:0] shift_q;
	logic [7:0] second_q;
	logic       two_q;
	logic [2:0] bitcnt_q;
	logic       valid_q;
	logic       data_q;
	logic       clock_q;
	logic       last_q;

	logic [3:0] bright_sat;
	logic [3:0] bright_m1;
	logic [7:0] first_byte;
	logic       fire;
	logic       dbit;

	always_comb begin
		bright_sat = (brightness > 4'(MAX_BRIGHTNESS)) ? 4'(MAX_BRIGHTNESS) : brightness;
		bright_m1  = bright_sat - 4'd1;
		case (mode)
			MODE_SETUP:  first_byte = CMD_DATA_AUTO;
			MODE_BRIGHT: first_byte = (bright_sat == 4'd0) ? CMD_DISPLAY_OFF
				: (CMD_DISPLAY_ON | {5'd0, bright_m1[2:0]});
			MODE_GRID:   first_byte = CMD_ADDRESS | {4'd0, grid[3:0]};
			default:     first_byte = CMD_DATA_AUTO;
		endcase
	end

	assign st.go       = (mode == MODE_SETUP) || (mode == MODE_BRIGHT)
		|| ((mode == MODE_GRID) && (grid < 8'(GRID_COUNT)));
	assign st.byte_end = (bitcnt_q == 3'd7);
	assign st.more     = two_q;
	assign st.out_free = !valid_q || !out_stall;

	assign fire = uword.emit && st.out_free;

	always_comb begin
		case (uword.dsrc)
			DS_ZERO: dbit = 1'b0;
			DS_ONE:  dbit = 1'b1;
			DS_BIT:  dbit = shift_q[0];
			default: dbit = 1'b1;
		endcase
	end

	// bit shifter; the second byte takes over after bit 7 of the first
	always_ff @(posedge clk) begin
		if (load) begin
			shift_q  <= first_byte;
			second_q <= dots;
		end else if (fire && uword.shift) begin
			if (st.byte_end && two_q)
				shift_q <= second_q;
			else
				shift_q <= {1'b0, shift_q[7:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_q    <= 1'b0;
			bitcnt_q <= 3'd0;
			valid_q  <= 1'b0;
		end else begin
			if (load) begin
				two_q    <= (mode == MODE_GRID);
				bitcnt_q <= 3'd0;
			end else if (fire && uword.shift) begin
				bitcnt_q <= bitcnt_q + 3'd1;
				if (st.byte_end)
					two_q <= 1'b0;
			end
			if (fire)
				valid_q <= 1'b1;
			else if (!out_stall)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_q  <= dbit;
			clock_q <= uword.clk_lvl;
			last_q  <= uword.last;
		end
	end

	assign out_valid   = valid_q;
	assign data_level  = data_q;
	assign clock_level = clock_q;
	assign last        = last_q;

endmodule

FILE: design/led_matrix_serial_command_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_serial_command_sender
// Turns one command request into the pin-state frame of a two-wire LED driver.
// ----------------------------------------------------------------------------
// Each accepted request yields one frame of pin states, one per output
// request: a start state, each byte LSB first as (bit, clock low) then
// (bit, clock high), and three stop states, the final one flagged by last.
// Setup and brightness requests give 20 states, grid writes 36; a grid write
// to a grid of 16 or more and mode 3 give nothing. A small microprogram
// steps through the frame one state per cycle while the output does not
// stall, starting after an accept step that takes the request; an ignored
// request leaves the sequencer in its idle step. New requests are taken
// only while the sequencer waits in its idle step, though the last state
// may still sit in the output register.
// ----------------------------------------------------------------------------
module led_matrix_serial_command_sender
	import lmscs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  logic [3:0] brightness,
	input  logic [7:0] grid,
	input  logic [7:0] dots,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       data_level,
	output logic       clock_level,
	output logic       last
);

	ucode_t     uword;
	dp_status_t st;
	logic       load;

	lmscs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.uword    (uword),
		.load     (load),
		.in_stall (in_stall)
	);

	lmscs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.brightness  (brightness),
		.grid        (grid),
		.dots        (dots),
		.load        (load),
		.uword       (uword),
		.st          (st),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_level  (data_level),
		.clock_level (clock_level),
		.last        (last)
	);

endmodule
